FILE: design/aqf_pkg.sv
// shared types, constants and helper functions for the ascii query framer
// no dependencies; used by the core and the testbench
package aqf_pkg;

    localparam int HDR_LEN   = 8;
    localparam int FRAME_LEN = 10;
    localparam int POS_W     = $clog2(FRAME_LEN);

    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(HDR_LEN);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam logic [7:0] START_CHAR_RST = 8'h02;
    localparam logic [7:0] END_CHAR_RST   = 8'h05;

    localparam logic [7:0] ASCII_ZERO     = 8'h30;
    localparam logic [7:0] ASCII_A_OFFSET = 8'h57;  // 'a' - 10
    localparam logic [3:0] HEX_TEN        = 4'd10;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_CHAR = 1'b0,
        REG_END_CHAR   = 1'b1
    } cfg_reg_t;

    // one lowercase hex digit
    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < HEX_TEN) ? (ASCII_ZERO + wide) : (ASCII_A_OFFSET + wide);
    endfunction

    // crc-16/arc update by one byte, reflected, lsb first
    function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc_in,
                                                   input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: design/aqf_ifs.sv
// valid/ready channel interfaces: query input beat and frame byte output beat
// depends on nothing beyond plain logic types
interface aqf_query_if;
    logic       valid;
    logic       ready;
    logic [3:0] node;
    logic [7:0] func_code;
    logic [3:0] tag_value;
    logic [3:0] start_axis;
    logic [3:0] axis_count;

    modport source (output valid, node, func_code, tag_value, start_axis, axis_count,
                    input ready);
    modport sink   (input valid, node, func_code, tag_value, start_axis, axis_count,
                    output ready);
endinterface

interface aqf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

FILE: design/ascii_query_frame_with_crc16_core.sv
// ascii query framer core: header build, serial crc-16/arc, byte output register
// depends on aqf_pkg and the interfaces in aqf_ifs.sv
//
//  channel   dir  width               notes
//  query     in   4+8+4+4+4 payload   one query per beat
//  frame     out  8 + last            ten beats per query, last on crc high byte
//  cfg       in   we, 1b index, 8b    start_char / end_char, write only
//
// one frame byte leaves per cycle, unless the frame side stalls, first from the shift
// register, then the crc; the crc is folded one header byte per cycle as it goes out
// the next query is taken in the cycle the tenth byte moves to the output register,
// so frames follow with no gap; a stall on the frame side freezes the whole engine
// rst_n clears control state and sets start_char=0x02, end_char=0x05
module ascii_query_frame_with_crc16_core (
    input  logic                           clk,
    input  logic                           rst_n,
    aqf_query_if.sink                      query,
    aqf_byte_if.source                     frame,
    input  logic                           cfg_we,
    input  logic [aqf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aqf_pkg::CFG_DATA_W-1:0] cfg_data
);

    // config registers
    logic [7:0] start_char_reg;
    logic [7:0] end_char_reg;

    // frame engine state
    logic                          busy_reg,    busy_next;
    logic [aqf_pkg::POS_W-1:0]     pos_reg,     pos_next;
    logic [aqf_pkg::HDR_LEN*8-1:0] hdr_reg,     hdr_next;
    logic [15:0]                   crc_reg,     crc_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg,  out_byte_next;
    logic       out_last_reg,  out_last_next;

    logic       out_free;     // output register can take a beat
    logic       advance;      // engine emits a byte this cycle
    logic       accept;       // query beat taken
    logic [7:0] emit_byte;

    // ---------------- config port ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= aqf_pkg::START_CHAR_RST;
            end_char_reg   <= aqf_pkg::END_CHAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (aqf_pkg::cfg_reg_t'(cfg_index))
                aqf_pkg::REG_START_CHAR: start_char_reg <= cfg_data;
                aqf_pkg::REG_END_CHAR:   end_char_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_free = !out_valid_reg || frame.ready;
    assign advance  = busy_reg && out_free;
    // free when idle, or when the last byte of the current frame goes out now
    assign query.ready = !busy_reg || (advance && (pos_reg == aqf_pkg::POS_LAST));
    assign accept      = query.valid && query.ready;

    // byte currently at the head of the frame
    always_comb
    begin
        if (pos_reg < aqf_pkg::POS_CRC_LO)
            emit_byte = hdr_reg[7:0];
        else if (pos_reg == aqf_pkg::POS_CRC_LO)
            emit_byte = crc_reg[7:0];
        else
            emit_byte = crc_reg[15:8];
    end

    // ---------------- engine next state ----------------
    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        hdr_next       = hdr_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (frame.ready)
            out_valid_next = 1'b0;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = (pos_reg == aqf_pkg::POS_LAST);
            if (pos_reg < aqf_pkg::POS_CRC_LO)
            begin
                // fold the outgoing header byte into the crc, shift the next one up
                crc_next = aqf_pkg::crc16_arc_byte(crc_reg, hdr_reg[7:0]);
                hdr_next = {8'h00, hdr_reg[aqf_pkg::HDR_LEN*8-1:8]};
            end
            if (pos_reg == aqf_pkg::POS_LAST)
                busy_next = 1'b0;
            else
                pos_next = pos_reg + 1'b1;
        end

        if (accept)
        begin
            // header, byte 0 in the low bits
            busy_next = 1'b1;
            pos_next  = '0;
            crc_next  = aqf_pkg::CRC_INIT;
            hdr_next  = {end_char_reg,
                         aqf_pkg::hex_ascii(query.axis_count),
                         aqf_pkg::hex_ascii(query.start_axis),
                         aqf_pkg::hex_ascii(query.tag_value),
                         aqf_pkg::hex_ascii(query.func_code[3:0]),
                         aqf_pkg::hex_ascii(query.func_code[7:4]),
                         aqf_pkg::hex_ascii(query.node),
                         start_char_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        hdr_reg      <= hdr_next;
        crc_reg      <= crc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign frame.valid     = out_valid_reg;
    assign frame.out_byte  = out_byte_reg;
    assign frame.last_byte = out_last_reg;

    // ---------------- assertions ----------------
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg <= aqf_pkg::POS_LAST))
        else $error("byte position past end of frame");

    a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (pos_reg != aqf_pkg::POS_LAST)) |-> !query.ready)
        else $error("query taken while frame in progress");

    a_accept_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && (pos_reg == '0)))
        else $error("accepted query did not start a frame");

    a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (pos_reg == aqf_pkg::POS_LAST)) |=> (out_valid_reg && out_last_reg))
        else $error("tenth byte not marked last");

    a_last_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (pos_reg != aqf_pkg::POS_LAST)) |=> !out_last_reg)
        else $error("last marked before end of frame");

endmodule

FILE: bench/tb.sv
// testbench for the ascii query framer core: directed and random queries, checked beat by beat
// depends on aqf_pkg, the channel interfaces in aqf_ifs.sv and ascii_query_frame_with_crc16_core
module tb;

    localparam int          CLK_HALF     = 6;
    localparam int          QUIET_LIMIT  = 2000;   // cycles with no beat on either channel
    localparam int          SETTLE_CYC   = 16;     // frame latency plus margin
    localparam int          TAIL_CYC     = 30;
    localparam int          RAND_PER_SET = 90;
    localparam int          IDLE_PCT     = 6;
    localparam logic [15:0] ARC_POLY     = 16'hA001;   // reflected crc-16/arc polynomial

    typedef struct packed {
        logic [3:0] node;
        logic [7:0] func_code;
        logic [3:0] tag_value;
        logic [3:0] start_axis;
        logic [3:0] axis_count;
    } query_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } frame_beat_t;

    // builds the expected frame for each accepted query and checks frame beats in order
    class frame_scoreboard;
        logic [7:0]  start_char;
        logic [7:0]  end_char;
        frame_beat_t pending_beats[$];
        int          errors;

        function new();
            start_char = aqf_pkg::START_CHAR_RST;
            end_char   = aqf_pkg::END_CHAR_RST;
            errors     = 0;
        endfunction

        function void set_reg(aqf_pkg::cfg_reg_t idx, logic [7:0] val);
            case (idx)
                aqf_pkg::REG_START_CHAR: start_char = val;
                aqf_pkg::REG_END_CHAR:   end_char   = val;
            endcase
        endfunction

        // lowercase hex digit: '0' is 8'h30, 'a' is 8'h61
        function logic [7:0] hex_char(logic [3:0] nib);
            return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h61 + {4'h0, nib} - 8'd10);
        endfunction

        function void push_beat(logic [7:0] value, logic last);
            frame_beat_t fb;
            fb.value = value;
            fb.last  = last;
            pending_beats.push_back(fb);
        endfunction

        function void note_query(query_t q);
            logic [7:0]  hdr[8];
            logic [15:0] crc;
            hdr[0] = start_char;
            hdr[1] = hex_char(q.node);
            hdr[2] = hex_char(q.func_code[7:4]);
            hdr[3] = hex_char(q.func_code[3:0]);
            hdr[4] = hex_char(q.tag_value);
            hdr[5] = hex_char(q.start_axis);
            hdr[6] = hex_char(q.axis_count);
            hdr[7] = end_char;
            crc = 16'h0000;
            foreach (hdr[i])
            begin
                crc = crc ^ {8'h00, hdr[i]};
                for (int b = 0; b < 8; b++)
                    crc = crc[0] ? ((crc >> 1) ^ ARC_POLY) : (crc >> 1);
                push_beat(hdr[i], 1'b0);
            end
            push_beat(crc[7:0], 1'b0);
            push_beat(crc[15:8], 1'b1);
        endfunction

        function void check_byte(logic [7:0] value, logic last);
            frame_beat_t exp_beat;
            if (pending_beats.size() == 0)
            begin
                errors++;
                $display("%0t: extra frame beat, expected none, got out_byte=%02h last_byte=%0b",
                         $time, value, last);
                return;
            end
            exp_beat = pending_beats.pop_front();
            if (value !== exp_beat.value)
            begin
                errors++;
                $display("%0t: out_byte mismatch, expected %02h, got %02h",
                         $time, exp_beat.value, value);
            end
            if (last !== exp_beat.last)
            begin
                errors++;
                $display("%0t: last_byte mismatch, expected %0b, got %0b",
                         $time, exp_beat.last, last);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    aqf_pkg::cfg_reg_t cfg_index;
    logic [7:0]        cfg_data;
    logic              steady;          // high: neither side idles
    int                quiet_cycles = 0;
    frame_scoreboard   sb = new();

    aqf_query_if q_if ();
    aqf_byte_if  f_if ();

    ascii_query_frame_with_crc16_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (q_if),
        .frame     (f_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // free-running clock, period 12
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // frame side: ready drops at random, about 6 percent of the time, unless steady
    initial
    begin
        f_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            f_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor at the rising edge: query beats feed the predictor, frame beats are checked
    // a query beat is noted before any frame beat of the same edge, so order is fixed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (q_if.valid && q_if.ready)
                sb.note_query({q_if.node, q_if.func_code, q_if.tag_value,
                               q_if.start_axis, q_if.axis_count});
            if (f_if.valid === 1'b1 && f_if.ready)
                sb.check_byte(f_if.out_byte, f_if.last_byte);
            // any beat on either side counts as progress
            if ((q_if.valid && q_if.ready) || (f_if.valid === 1'b1 && f_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
    end

    // watchdog: a long run with no beat anywhere means the block hung
    initial
    begin
        do @(negedge clk); while (quiet_cycles < QUIET_LIMIT);
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    function automatic query_t make_query(logic [3:0] node, logic [7:0] func_code,
                                          logic [3:0] tag_value, logic [3:0] start_axis,
                                          logic [3:0] axis_count);
        query_t q;
        q.node       = node;
        q.func_code  = func_code;
        q.tag_value  = tag_value;
        q.start_axis = start_axis;
        q.axis_count = axis_count;
        return q;
    endfunction

    function automatic query_t rand_query();
        return make_query(4'($urandom_range(15)), 8'($urandom_range(255)),
                          4'($urandom_range(15)), 4'($urandom_range(15)),
                          4'($urandom_range(15)));
    endfunction

    // entered and left at a falling edge; random idle cycles ahead of the beat unless steady
    task automatic send_query(query_t q);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            q_if.valid <= 1'b0;
            @(negedge clk);
        end
        q_if.valid      <= 1'b1;
        q_if.node       <= q.node;
        q_if.func_code  <= q.func_code;
        q_if.tag_value  <= q.tag_value;
        q_if.start_axis <= q.start_axis;
        q_if.axis_count <= q.axis_count;
        do @(posedge clk); while (!q_if.ready);
        @(negedge clk);
    endtask

    // wait for every expected beat, then let the engine go quiet
    task automatic drain();
        q_if.valid <= 1'b0;
        while (sb.pending_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // only called with the block idle
    task automatic write_reg(aqf_pkg::cfg_reg_t idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    // one configuration setting followed by a batch of random queries
    task automatic run_phase(logic [7:0] sc, logic [7:0] ec, logic calm);
        write_reg(aqf_pkg::REG_START_CHAR, sc);
        write_reg(aqf_pkg::REG_END_CHAR, ec);
        steady <= calm;
        repeat (RAND_PER_SET) send_query(rand_query());
        drain();
        steady <= 1'b0;
    endtask

    initial
    begin
        query_t directed[$];

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = aqf_pkg::REG_START_CHAR;
        cfg_data        = 8'h00;
        steady          = 1'b0;
        q_if.valid      = 1'b0;
        q_if.node       = '0;
        q_if.func_code  = '0;
        q_if.tag_value  = '0;
        q_if.start_axis = '0;
        q_if.axis_count = '0;

        // field extremes and the 9/a digit boundary in every position
        directed.push_back(make_query(4'h0, 8'h00, 4'h0, 4'h0, 4'h0));
        directed.push_back(make_query(4'hf, 8'hff, 4'hf, 4'hf, 4'hf));
        directed.push_back(make_query(4'h9, 8'h99, 4'h9, 4'h9, 4'h9));
        directed.push_back(make_query(4'ha, 8'haa, 4'ha, 4'ha, 4'ha));
        directed.push_back(make_query(4'h0, 8'h09, 4'h0, 4'h0, 4'h0));
        directed.push_back(make_query(4'h0, 8'h0a, 4'h0, 4'h0, 4'h0));
        directed.push_back(make_query(4'h0, 8'h90, 4'h0, 4'h0, 4'h0));
        directed.push_back(make_query(4'h0, 8'ha0, 4'h0, 4'h0, 4'h0));
        directed.push_back(make_query(4'h5, 8'h5a, 4'ha, 4'h5, 4'ha));
        directed.push_back(make_query(4'ha, 8'ha5, 4'h5, 4'ha, 4'h5));
        directed.push_back(make_query(4'hf, 8'h00, 4'h0, 4'hf, 4'h0));
        directed.push_back(make_query(4'h0, 8'hff, 4'hf, 4'h0, 4'hf));
        directed.push_back(make_query(4'h1, 8'h23, 4'h4, 4'h5, 4'h6));
        directed.push_back(make_query(4'hc, 8'hde, 4'hb, 4'he, 4'hf));
        directed.push_back(make_query(4'h7, 8'h80, 4'h8, 4'h1, 4'h7));
        directed.push_back(make_query(4'h3, 8'h0f, 4'hc, 4'hd, 4'h2));

        // reset held low from the start, released at a falling edge
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed queries under the reset start and end characters
        foreach (directed[i])
            send_query(directed[i]);
        drain();

        // extremes of both registers, one random setting, then back to the defaults
        run_phase(8'h00, 8'hff, 1'b0);
        run_phase(8'hff, 8'h00, 1'b1);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
        run_phase(aqf_pkg::START_CHAR_RST, aqf_pkg::END_CHAR_RST, 1'b0);

        // tail: any stray beat after the last frame shows up as unexpected
        repeat (TAIL_CYC) @(posedge clk);
        if (sb.errors == 0 && sb.pending_beats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
